// File: hw/rtl/lru_fully_associative_cache_assert.svh
// ----------------------------------------------------------------------------
// lru_fully_associative_cache_assert.svh
// Assertion macros shared by the LRU cache RTL; clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef LRU_FULLY_ASSOCIATIVE_CACHE_ASSERT_SVH
`define LRU_FULLY_ASSOCIATIVE_CACHE_ASSERT_SVH

// cond holds at every edge out of reset
`define LFAC_ASSERT_HOLDS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// ante implies cons in the same cycle
`define LFAC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante implies cons in the next cycle
`define LFAC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/lfac_pkg.sv
// ----------------------------------------------------------------------------
// lfac_pkg
// Sizes, register codes and the entry type of the LRU cache.
// ----------------------------------------------------------------------------
package lfac_pkg;

    localparam int ENTRIES   = 64;
    localparam int KEY_PARTS = 4;

    localparam int PART_W = 16;
    localparam int KEY_W  = PART_W * KEY_PARTS;
    localparam int VAL_W  = 32;
    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int CAP_W  = 7;
    localparam int OCC_W  = 7;
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // register index = paddr[2]
    localparam logic REG_CAPACITY = 1'b0;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } entry_t;

endpackage

// File: hw/rtl/lru_fully_associative_cache.sv
// ----------------------------------------------------------------------------
// lru_fully_associative_cache
// Fully associative cache kept as a recency-ordered chain of entry cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) takes one word per item: kind
//   (0 lookup, 1 insert), key_part_0..3 and entry_value. Output channel
//   (out_valid / out_stall) returns one word per item: hit, found_value
//   and occupancy after the item.
//   Steps: accept edge, compare edge, update edge; the result word is
//   registered at the update edge and then shows on the output.
//   A new item enters the compare stage (every cell against the probe
//   key, first-match search) only once the last one has passed the update
//   stage (selected entry to the head, chain shifts one rank).
//   A new word is taken in the same cycle the previous one updates, so the
//   output register parts the two channels.
//   When the receiver stalls, the result word holds and the update of the
//   next item waits for it; input then stalls as well.
//   Reset clears occupancy and sets capacity_limit to 64. Entry cells are
//   not cleared; ranks at or above occupancy are never matched.
//   capacity_limit sits at APB address 0; write only while idle.
// ----------------------------------------------------------------------------
module lru_fully_associative_cache
    import lfac_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    // input channel
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     kind,
    input  logic signed [PART_W-1:0] key_part_0,
    input  logic signed [PART_W-1:0] key_part_1,
    input  logic signed [PART_W-1:0] key_part_2,
    input  logic signed [PART_W-1:0] key_part_3,
    input  logic [VAL_W-1:0]         entry_value,
    // output channel
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     hit,
    output logic [VAL_W-1:0]         found_value,
    output logic [OCC_W-1:0]         occupancy,
    // config port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    `include "lru_fully_associative_cache_assert.svh"

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;

    // ---------------- config register ----------------
    logic [CAP_W-1:0] cap_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & (paddr[2] == REG_CAPACITY);
    assign prdata = (paddr[2] == REG_CAPACITY) ? 32'(cap_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= CAP_RESET;
        else if (cfg_wr)
            cap_reg <= pwdata[CAP_W-1:0];
    end

    // ---------------- control ----------------
    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic             in_fire;
    logic             upd_fire;
    logic             out_valid_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // update waits only while an untaken result holds the output register
    assign upd_fire = (state_reg == ST_UPD) & ~(out_valid_reg & out_stall);
    assign in_stall = ~((state_reg == ST_IDLE) | upd_fire);
    assign in_fire  = in_valid & ~in_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_fire) state_next = ST_CMP;
            ST_CMP:  state_next = ST_UPD;
            ST_UPD:
            begin
                if (upd_fire)
                    state_next = in_fire ? ST_CMP : ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (upd_fire)
            begin
                out_valid_reg <= 1'b1;
                count_reg     <= count_next;
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // ---------------- input word capture ----------------
    logic             kind_reg;
    logic [KEY_W-1:0] probe_reg;
    logic [VAL_W-1:0] val_in_reg;
    logic [KEY_W-1:0] probe_key;

    // only the first KEY_PARTS parts form the key
    always_comb
    begin
        logic [PART_W-1:0] parts [0:3];
        parts[0] = key_part_0;
        parts[1] = key_part_1;
        parts[2] = key_part_2;
        parts[3] = key_part_3;
        for (int p = 0; p < KEY_PARTS; p++)
            probe_key[p*PART_W +: PART_W] = parts[p];
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            kind_reg   <= kind;
            probe_reg  <= probe_key;
            val_in_reg <= entry_value;
        end
    end

    // ---------------- cell chain ----------------
    entry_t             chain [0:ENTRIES-1];
    entry_t             head_in;
    logic [ENTRIES-1:0] key_eq;
    logic [ENTRIES-1:0] live;
    logic [ENTRIES-1:0] shift_en;

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++)
        begin : g_cell
            entry_t cell_in;
            if (g == 0)
            begin : g_head
                assign cell_in = head_in;
            end
            else
            begin : g_body
                assign cell_in = chain[g-1];
            end

            lfac_cell u_cell (
                .clk       (clk),
                .shift_en  (shift_en[g]),
                .entry_in  (cell_in),
                .probe_key (probe_reg),
                .entry_out (chain[g]),
                .key_eq    (key_eq[g])
            );

            assign live[g] = (CNT_W'(g) < count_reg);
        end
    endgenerate

    // ---------------- compare stage: first match by rank ----------------
    logic [ENTRIES-1:0] match;
    logic [ENTRIES-1:0] lvl [0:IDX_W];
    logic [ENTRIES-1:0] above;
    logic [ENTRIES-1:0] first_reg;
    logic [ENTRIES-1:0] move_reg;
    logic               hit_reg;

    assign match = key_eq & live;

    // log-depth prefix OR: lvl[IDX_W][i] = any match at rank 0..i
    always_comb
    begin
        lvl[0] = match;
        for (int l = 0; l < IDX_W; l++)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (i >= (1 << l))
                    lvl[l+1][i] = lvl[l][i] | lvl[l][i - (1 << l)];
                else
                    lvl[l+1][i] = lvl[l][i];
            end
        end
    end

    assign above = {lvl[IDX_W][ENTRIES-2:0], 1'b0};

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CMP)
        begin
            first_reg <= match & ~above;
            hit_reg   <= |match;
            // ranks up to and including the hit move down one
            move_reg  <= {ENTRIES{|match}} & ~above;
        end
    end

    // ---------------- update stage ----------------
    entry_t sel_entry;

    always_comb
    begin
        sel_entry = '0;
        for (int i = 0; i < ENTRIES; i++)
            if (first_reg[i])
                sel_entry = sel_entry | chain[i];
    end

    assign head_in  = kind_reg ? entry_t'{key: probe_reg, value: val_in_reg} : sel_entry;
    assign shift_en = {ENTRIES{upd_fire}} & ({ENTRIES{kind_reg}} | move_reg);

    logic [CMP_W-1:0] cap_ext;
    logic [CNT_W-1:0] lim;
    logic [CNT_W-1:0] grown;

    always_comb
    begin
        cap_ext = CMP_W'(cap_reg);
        lim     = (cap_ext > CMP_W'(ENTRIES)) ? CNT_W'(ENTRIES) : CNT_W'(cap_ext);
        // full chain: tail entry falls off
        grown   = (count_reg >= CNT_W'(ENTRIES)) ? CNT_W'(ENTRIES) : count_reg + 1'b1;
        if (kind_reg)
            count_next = (grown > lim) ? lim : grown;
        else
            count_next = count_reg;
    end

    // ---------------- result word ----------------
    logic             hit_out_reg;
    logic [VAL_W-1:0] found_reg;
    logic [OCC_W-1:0] occ_reg;

    always_ff @(posedge clk)
    begin
        if (upd_fire)
        begin
            hit_out_reg <= ~kind_reg & hit_reg;
            found_reg   <= (~kind_reg & hit_reg) ? sel_entry.value : '0;
            occ_reg     <= OCC_W'(count_next);
        end
    end

    assign out_valid   = out_valid_reg;
    assign hit         = hit_out_reg;
    assign found_value = found_reg;
    assign occupancy   = occ_reg;

    // ---------------- checks ----------------
    `LFAC_ASSERT_HOLDS(a_count_range, count_reg <= CNT_W'(ENTRIES),
        "occupancy beyond chain length")
    `LFAC_ASSERT_IMPL(a_first_onehot, state_reg == ST_UPD,
        $onehot0(first_reg) && (hit_reg == (|first_reg)), "first match not unique")
    `LFAC_ASSERT_IMPL(a_accept_state, in_fire,
        (state_reg == ST_IDLE) || (state_reg == ST_UPD), "word taken while busy")
    `LFAC_ASSERT_NEXT(a_result_shown, upd_fire, out_valid_reg,
        "update without result word")
    `LFAC_ASSERT_NEXT(a_insert_no_hit, upd_fire && kind_reg, !hit_out_reg && (found_reg == '0),
        "insert reported a hit")

endmodule

// File: hw/rtl/lfac_cell.sv
// ----------------------------------------------------------------------------
// lfac_cell
// One rank of the recency chain: holds an entry, loads from its neighbor.
// ----------------------------------------------------------------------------
module lfac_cell
    import lfac_pkg::*;
(
    input  logic             clk,
    input  logic             shift_en,
    input  entry_t           entry_in,
    input  logic [KEY_W-1:0] probe_key,
    output entry_t           entry_out,
    output logic             key_eq
);

    entry_t entry_reg;
    entry_t entry_next;

    assign entry_next = shift_en ? entry_in : entry_reg;

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry_out = entry_reg;
    assign key_eq    = (entry_reg.key == probe_key);

endmodule
